### sv/cvp_pkg.sv
// Shared types and constants for the cubic velocity profile core.
package cvp_pkg;

  localparam int VEL_W  = 12;
  localparam int TIME_W = 16;
  localparam int OUT_W  = 48;

  // Widths of the divider operands: the widest numerator is dv*tau^4,
  // the widest denominator is 2*T^3.
  localparam int NUM_W = VEL_W + 4 * TIME_W;
  localparam int DEN_W = 3 * TIME_W + 1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_ZERO_RAMP = 2'd1;
  localparam logic [1:0] STATUS_SAT       = 2'd2;

  typedef struct packed {
    logic signed [VEL_W-1:0] start_velocity;
    logic signed [VEL_W-1:0] end_velocity;
    logic [TIME_W-1:0]       ramp_start_time;
    logic [TIME_W-1:0]       ramp_end_time;
    logic [TIME_W-1:0]       query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] distance_so_far;
    logic signed [OUT_W-1:0] velocity_now;
    logic [1:0]              status;
  } out_item_t;

endpackage

### sv/cvp_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module cvp_div #(
  parameter int NW = 76,
  parameter int DW = 49
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quot
);

  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] nq_r  [NW];
  logic [DW-1:0] den_r [NW];

  // Each stage shifts in one numerator bit, compares and subtracts.
  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [NW-1:0] nq_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign nq_in  = nq_r[k-1];
      assign den_in = den_r[k-1];
    end

    assign trial = {rem_in, nq_in[NW-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        nq_r[k]  <= {nq_in[NW-2:0], ge};
        den_r[k] <= den_in;
      end
    end
  end

  assign quot = nq_r[NW-1];

endmodule

### sv/cubic_velocity_profile_core.sv
// Top level of the cubic velocity profile core: power chain, dividers, sum and clamp.
//
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid / in_stall | cvp_pkg::in_item_t
// out_    | output    | out_valid/out_stall | cvp_pkg::out_item_t
//
// One transaction may enter every cycle while in_stall is low; most of the pipeline lies in
// the four restoring dividers, which resolve one quotient bit per stage.
// Reset clears only the valid bits; data registers are not reset.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated;
// in_stall is high exactly while a result waits under out_stall.
module cubic_velocity_profile_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cvp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cvp_pkg::out_item_t out_data
);

  localparam int VW    = cvp_pkg::VEL_W;
  localparam int TW    = cvp_pkg::TIME_W;
  localparam int OW    = cvp_pkg::OUT_W;
  localparam int NW    = cvp_pkg::NUM_W;
  localparam int DW    = cvp_pkg::DEN_W;
  localparam int A1_W  = VW + TW;
  localparam int A2_W  = VW + 2 * TW;
  localparam int A3_W  = VW + 3 * TW;
  localparam int A4_W  = VW + 4 * TW;
  localparam int VT_W  = VW + TW + 1;
  localparam int SUM_W = NW + 3;
  // Side data: v0*tau, v0, four sign flags, zero-interval flag.
  localparam int SIDE_W = VT_W + VW + 5;
  localparam int SIDE_D = 5 + NW;
  localparam int VLD_D  = 7 + NW;

  logic en;
  logic [VLD_D-1:0] vld_r;
  logic out_valid_r;
  cvp_pkg::out_item_t out_data_r;

  // The whole pipeline moves unless a finished result is held back.
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[VLD_D-2:0], in_valid};
      out_valid_r <= vld_r[VLD_D-1];
    end
  end

  // Stage 1: differences, magnitudes and signs.
  logic signed [VW:0] dv_c;
  logic signed [TW:0] tau_c, rt_c;
  logic [VW:0] dv_abs;
  logic [TW:0] tau_abs, rt_abs;
  logic [VW-1:0] dvm_r;
  logic [TW-1:0] tm_r, rtm_r;
  logic signed [TW:0] tau_r;
  logic signed [VW-1:0] v0_r;
  logic dvn_r, tn_r, rtn_r, zero_r;

  always_comb begin
    dv_c    = (VW+1)'(in_data.end_velocity) - (VW+1)'(in_data.start_velocity);
    tau_c   = $signed({1'b0, in_data.query_time}) - $signed({1'b0, in_data.ramp_start_time});
    rt_c    = $signed({1'b0, in_data.ramp_end_time}) - $signed({1'b0, in_data.ramp_start_time});
    dv_abs  = dv_c[VW] ? (VW+1)'(-dv_c) : dv_c;
    tau_abs = tau_c[TW] ? (TW+1)'(-tau_c) : tau_c;
    rt_abs  = rt_c[TW] ? (TW+1)'(-rt_c) : rt_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvm_r  <= dv_abs[VW-1:0];
      tm_r   <= tau_abs[TW-1:0];
      rtm_r  <= rt_abs[TW-1:0];
      tau_r  <= tau_c;
      v0_r   <= in_data.start_velocity;
      dvn_r  <= dv_c[VW];
      tn_r   <= tau_c[TW];
      rtn_r  <= rt_c[TW];
      zero_r <= (rt_c == '0);
    end
  end

  // Stage 2: first products and the side bundle.
  logic [A1_W-1:0] a1_r;
  logic [2*TW-1:0] t2_s2_r;
  logic [TW-1:0] tm_s2_r, rtm_s2_r;
  logic signed [VT_W-1:0] v0tau_c;
  logic [SIDE_W-1:0] side_r [SIDE_D];
  logic neg1_c, neg2_c, neg3_c, neg4_c;

  always_comb begin
    v0tau_c = VT_W'(v0_r) * VT_W'(tau_r);
    neg1_c  = dvn_r ^ rtn_r ^ 1'b1;
    neg2_c  = dvn_r ^ tn_r;
    neg3_c  = dvn_r ^ tn_r ^ rtn_r ^ 1'b1;
    neg4_c  = dvn_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r     <= A1_W'(dvm_r) * A1_W'(tm_r);
      t2_s2_r  <= (2*TW)'(rtm_r) * (2*TW)'(rtm_r);
      tm_s2_r  <= tm_r;
      rtm_s2_r <= rtm_r;
      side_r[0] <= {v0tau_c, v0_r, neg1_c, neg2_c, neg3_c, neg4_c, zero_r};
    end
  end

  // Side data delay line, aligned with the divider outputs.
  for (genvar i = 1; i < SIDE_D; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // Stage 3: dv*tau^2 and T^3.
  logic [A2_W-1:0] a2_r;
  logic [3*TW-1:0] t3_s3_r;
  logic [2*TW-1:0] t2_s3_r;
  logic [TW-1:0] tm_s3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a2_r    <= A2_W'(a1_r) * A2_W'(tm_s2_r);
      t3_s3_r <= (3*TW)'(t2_s2_r) * (3*TW)'(rtm_s2_r);
      t2_s3_r <= t2_s2_r;
      tm_s3_r <= tm_s2_r;
    end
  end

  // Stage 4: dv*tau^3.
  logic [A3_W-1:0] a3_r;
  logic [A2_W-1:0] a2_s4_r;
  logic [3*TW-1:0] t3_s4_r;
  logic [2*TW-1:0] t2_s4_r;
  logic [TW-1:0] tm_s4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a3_r    <= A3_W'(a2_r) * A3_W'(tm_s3_r);
      a2_s4_r <= a2_r;
      t3_s4_r <= t3_s3_r;
      t2_s4_r <= t2_s3_r;
      tm_s4_r <= tm_s3_r;
    end
  end

  // Stage 5: dv*tau^4.
  logic [A4_W-1:0] a4_r;
  logic [A3_W-1:0] a3_s5_r;
  logic [A2_W-1:0] a2_s5_r;
  logic [3*TW-1:0] t3_s5_r;
  logic [2*TW-1:0] t2_s5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a4_r    <= A4_W'(a3_r) * A4_W'(tm_s4_r);
      a3_s5_r <= a3_r;
      a2_s5_r <= a2_s4_r;
      t3_s5_r <= t3_s4_r;
      t2_s5_r <= t2_s4_r;
    end
  end

  // Stage 6: divider operands with their constant factors.
  logic [NW-1:0] n1_r, n2_r, n3_r, n4_r;
  logic [DW-1:0] d1_r, d2_r, d3_r, d4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r <= NW'(a4_r);
      d1_r <= DW'({t3_s5_r, 1'b0});
      n2_r <= NW'(a3_s5_r);
      d2_r <= DW'(t2_s5_r);
      n3_r <= NW'({a3_s5_r, 1'b0});
      d3_r <= DW'(t3_s5_r);
      n4_r <= NW'(a2_s5_r) + NW'({a2_s5_r, 1'b0});
      d4_r <= DW'(t2_s5_r);
    end
  end

  logic [NW-1:0] q1, q2, q3, q4;

  cvp_div #(.NW(NW), .DW(DW)) u_div1 (.clk(clk), .en(en), .num(n1_r), .den(d1_r), .quot(q1));
  cvp_div #(.NW(NW), .DW(DW)) u_div2 (.clk(clk), .en(en), .num(n2_r), .den(d2_r), .quot(q2));
  cvp_div #(.NW(NW), .DW(DW)) u_div3 (.clk(clk), .en(en), .num(n3_r), .den(d3_r), .quot(q3));
  cvp_div #(.NW(NW), .DW(DW)) u_div4 (.clk(clk), .en(en), .num(n4_r), .den(d4_r), .quot(q4));

  // Signing stage: apply each term's sign.
  logic [SIDE_W-1:0] side_d;
  logic signed [NW:0] sq1_r, sq2_r, sq3_r, sq4_r;
  logic signed [VT_W-1:0] v0tau_sn_r;
  logic signed [VW-1:0] v0_sn_r;
  logic zero_sn_r;

  assign side_d = side_r[SIDE_D-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq1_r <= side_d[4] ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
      sq2_r <= side_d[3] ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
      sq3_r <= side_d[2] ? -$signed({1'b0, q3}) : $signed({1'b0, q3});
      sq4_r <= side_d[1] ? -$signed({1'b0, q4}) : $signed({1'b0, q4});
      v0tau_sn_r <= side_d[SIDE_W-1 -: VT_W];
      v0_sn_r    <= side_d[VW+4 -: VW];
      zero_sn_r  <= side_d[0];
    end
  end

  // Output stage: sums, clamp to the signed output range, and the zero-ramp override.
  logic signed [SUM_W-1:0] dsum, vsum;
  logic dfit, vfit;
  cvp_pkg::out_item_t res_nxt;

  always_comb begin
    dsum = SUM_W'(sq1_r) + SUM_W'(sq2_r) + SUM_W'(v0tau_sn_r);
    vsum = SUM_W'(sq3_r) + SUM_W'(sq4_r) + SUM_W'(v0_sn_r);
    dfit = (&dsum[SUM_W-1:OW-1]) || !(|dsum[SUM_W-1:OW-1]);
    vfit = (&vsum[SUM_W-1:OW-1]) || !(|vsum[SUM_W-1:OW-1]);
    res_nxt.distance_so_far = dfit ? dsum[OW-1:0] : {dsum[SUM_W-1], {(OW-1){!dsum[SUM_W-1]}}};
    res_nxt.velocity_now    = vfit ? vsum[OW-1:0] : {vsum[SUM_W-1], {(OW-1){!vsum[SUM_W-1]}}};
    res_nxt.status          = (dfit && vfit) ? cvp_pkg::STATUS_OK : cvp_pkg::STATUS_SAT;
    if (zero_sn_r) begin
      res_nxt.distance_so_far = '0;
      res_nxt.velocity_now    = '0;
      res_nxt.status          = cvp_pkg::STATUS_ZERO_RAMP;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A zero ramp interval always reports zero distance and velocity.
  a_zero_ramp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == cvp_pkg::STATUS_ZERO_RAMP |->
      out_data_r.distance_so_far == '0 && out_data_r.velocity_now == '0)
    else $error("zero ramp result not cleared");

  // A saturated status means at least one field sits at a clamp value.
  a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == cvp_pkg::STATUS_SAT |->
      out_data_r.distance_so_far == {1'b0, {(OW-1){1'b1}}} ||
      out_data_r.distance_so_far == {1'b1, {(OW-1){1'b0}}} ||
      out_data_r.velocity_now == {1'b0, {(OW-1){1'b1}}} ||
      out_data_r.velocity_now == {1'b1, {(OW-1){1'b0}}})
    else $error("saturated status without clamped field");

  // The status is always one of the defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.status == cvp_pkg::STATUS_OK ||
                     out_data_r.status == cvp_pkg::STATUS_ZERO_RAMP ||
                     out_data_r.status == cvp_pkg::STATUS_SAT))
    else $error("unused status code");

  // A newly raised out_valid must follow a transaction in the stage before it.
  a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(out_valid_r) && out_valid_r |-> $past(vld_r[VLD_D-1]))
    else $error("result appeared without a transaction");

endmodule

### test/tb.sv
// Testbench for the cubic velocity profile core: random and directed queries checked by a scoreboard.
`timescale 1ns / 100ps

module tb;

  localparam int VW        = cvp_pkg::VEL_W;
  localparam int TW        = cvp_pkg::TIME_W;
  localparam int OW        = cvp_pkg::OUT_W;
  localparam int LATENCY   = cvp_pkg::NUM_W + 8;
  localparam int N_RANDOM  = 1400;
  localparam int MAX_CYCLE = 200000;

  // Scoreboard: predicts each profile result and compares it with what the core returns.
  class profile_scoreboard;
    cvp_pkg::out_item_t pending[$];
    int                 errors;

    function new();
      errors = 0;
    endfunction

    // Signed truncating quotient of num / den, both exact 160-bit values.
    function logic signed [159:0] tdiv(logic signed [159:0] num,
                                       logic signed [159:0] den);
      logic [159:0] qm;
      logic         neg;
      neg = num[159] ^ den[159];
      qm  = (num[159] ? -num : num) / (den[159] ? -den : den);
      return neg ? -$signed(qm) : $signed(qm);
    endfunction

    // Clamp to 48 signed bits; sets flag when the value did not fit.
    function logic signed [OW-1:0] clamp48(logic signed [159:0] v, inout logic flag);
      logic signed [159:0] hi, lo;
      hi = (160'sd1 <<< (OW - 1)) - 1;
      lo = -(160'sd1 <<< (OW - 1));
      if (v > hi) begin
        flag = 1'b1;
        return hi[OW-1:0];
      end
      if (v < lo) begin
        flag = 1'b1;
        return lo[OW-1:0];
      end
      return v[OW-1:0];
    endfunction

    function void note_query(cvp_pkg::in_item_t q);
      logic signed [159:0] v0, dv, ramp, tau, t2, t3, t4, r2, r3, dist_v, vel_v;
      logic                sat;
      cvp_pkg::out_item_t  r;
      v0   = $signed({{(160-VW){q.start_velocity[VW-1]}}, q.start_velocity});
      dv   = $signed({{(160-VW){q.end_velocity[VW-1]}}, q.end_velocity}) - v0;
      ramp = $signed({144'd0, q.ramp_end_time}) - $signed({144'd0, q.ramp_start_time});
      tau  = $signed({144'd0, q.query_time}) - $signed({144'd0, q.ramp_start_time});
      if (ramp == 0) begin
        r.distance_so_far = '0;
        r.velocity_now    = '0;
        r.status          = cvp_pkg::STATUS_ZERO_RAMP;
      end else begin
        t2     = tau * tau;
        t3     = t2 * tau;
        t4     = t3 * tau;
        r2     = ramp * ramp;
        r3     = r2 * ramp;
        dist_v = -tdiv(dv * t4, 2 * r3) + tdiv(dv * t3, r2) + v0 * tau;
        vel_v  = -tdiv(2 * dv * t3, r3) + tdiv(3 * dv * t2, r2) + v0;
        sat    = 1'b0;
        r.distance_so_far = clamp48(dist_v, sat);
        r.velocity_now    = clamp48(vel_v, sat);
        r.status          = sat ? cvp_pkg::STATUS_SAT : cvp_pkg::STATUS_OK;
      end
      pending.push_back(r);
    endfunction

    function void check_result(cvp_pkg::out_item_t got);
      cvp_pkg::out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.distance_so_far !== want.distance_so_far) begin
        $display("%0t: distance expected %0d actual %0d", $time,
                 want.distance_so_far, got.distance_so_far);
        errors++;
      end
      if (got.velocity_now !== want.velocity_now) begin
        $display("%0t: velocity expected %0d actual %0d", $time,
                 want.velocity_now, got.velocity_now);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  cvp_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  cvp_pkg::out_item_t out_data;

  profile_scoreboard board = new();
  cvp_pkg::in_item_t queries[$];
  int                cycle = 0;

  cubic_velocity_profile_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #1 clk = ~clk;

  // Cycle limit guards against a hung pipeline.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("[cubic_velocity_profile_core] ERROR");
      $finish;
    end
  end

  // Sample accepted transactions on both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.note_query(in_data);
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  // Receiver: random stall lengths, with calm stretches of no stall.
  initial begin : receiver
    int wait_n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      wait_n = ((cycle / 3000) % 3 == 1) ? 0 : $urandom_range(0, 5);
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  function automatic cvp_pkg::in_item_t random_query();
    cvp_pkg::in_item_t q;
    int                t0, len;
    q.start_velocity = VW'($urandom);
    q.end_velocity   = VW'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        // Unconstrained fields: backward ramps, far queries, saturation.
        q.ramp_start_time = TW'($urandom);
        q.ramp_end_time   = TW'($urandom);
        q.query_time      = TW'($urandom);
      end
      1: begin
        q.ramp_start_time = TW'($urandom);
        q.ramp_end_time   = q.ramp_start_time;
        q.query_time      = TW'($urandom);
      end
      default: begin
        // Forward ramp with a query near or inside it.
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 300);
        t0  = $urandom_range(0, 65535 - len);
        q.ramp_start_time = TW'(t0);
        q.ramp_end_time   = TW'(t0 + len);
        q.query_time      = TW'(t0 + $urandom_range(0, len) -
                                (($urandom_range(0, 7) == 0) ? 5 : 0));
      end
    endcase
    return q;
  endfunction

  task automatic send_query(cvp_pkg::in_item_t q);
    int gap;
    gap = ((cycle / 2000) % 3 == 2) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_query(int v0, int v1, int t0, int t1, int tq);
    cvp_pkg::in_item_t q;
    q.start_velocity  = VW'(v0);
    q.end_velocity    = VW'(v1);
    q.ramp_start_time = TW'(t0);
    q.ramp_end_time   = TW'(t1);
    q.query_time      = TW'(tq);
    queries.push_back(q);
  endtask

  initial begin : driver
    int idle;
    // Directed cases: field extremes, zero ramp, query outside the ramp,
    // backward ramp and saturating results.
    add_query(0, 0, 0, 0, 0);
    add_query(2047, -2048, 100, 100, 500);
    add_query(-2048, 2047, 0, 65535, 65535);
    add_query(2047, -2048, 0, 65535, 32768);
    add_query(-2048, 2047, 0, 1, 65535);
    add_query(2047, -2048, 0, 1, 65535);
    add_query(2047, 2047, 0, 65535, 65535);
    add_query(-2048, -2048, 65535, 0, 0);
    add_query(100, 200, 1000, 900, 1100);
    add_query(10, 50, 500, 600, 400);
    add_query(-5, 5, 65535, 65534, 0);
    add_query(1000, -1000, 10, 20, 15);
    add_query(0, 1, 0, 3, 1);
    add_query(-1, 0, 0, 3, 2);
    add_query(300, -300, 40000, 40010, 40010);
    add_query(1, -1, 0, 65535, 1);
    add_query(-2048, 2047, 65535, 65535, 65535);
    add_query(12, 34, 2, 9, 0);
    for (int i = 0; i < N_RANDOM; i++) queries.push_back(random_query());

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (queries[i]) send_query(queries[i]);
    in_valid <= 1'b0;

    // Drain, then let the pipeline settle to catch stray results.
    while (board.pending.size() != 0) @(posedge clk);
    idle = 0;
    while (idle < 4 * LATENCY) begin
      @(posedge clk);
      idle++;
    end
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[cubic_velocity_profile_core] OK");
    end else begin
      $display("[cubic_velocity_profile_core] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
sv/cvp_pkg.sv
sv/cvp_div.sv
sv/cubic_velocity_profile_core.sv
test/tb.sv
